>>> rtl/core/xxtea_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA package
// Shared constants, the round-count table and the controller command type.
// ----------------------------------------------------------------------------
package xxtea_pkg;

    localparam int MAX_WORDS = 64;
    localparam int ADDR_W    = $clog2(MAX_WORDS);
    localparam int CNT_W     = $clog2(MAX_WORDS + 1);
    localparam int WORD_W    = 32;
    localparam int ROUND_W   = 6;
    localparam int KEY_CNT   = 4;
    localparam int KEY_IDX_W = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [WORD_W-1:0] DELTA = 32'h9e3779b9;

    localparam logic [1:0] ST_OK       = 2'd0;
    localparam logic [1:0] ST_SINGLE   = 2'd1;
    localparam logic [1:0] ST_OVERFLOW = 2'd2;

    // Number of rounds, 6 + 52 / n, as a range table on n.
    function automatic logic [ROUND_W-1:0] rounds_for(input logic [CNT_W-1:0] n);
        int unsigned nn;
        int unsigned q;
        nn = n;
        if (nn <= 2)       q = 26;
        else if (nn == 3)  q = 17;
        else if (nn == 4)  q = 13;
        else if (nn == 5)  q = 10;
        else if (nn == 6)  q = 8;
        else if (nn == 7)  q = 7;
        else if (nn == 8)  q = 6;
        else if (nn <= 10) q = 5;
        else if (nn <= 13) q = 4;
        else if (nn <= 17) q = 3;
        else if (nn <= 26) q = 2;
        else if (nn <= 52) q = 1;
        else               q = 0;
        return ROUND_W'(6 + q);
    endfunction

    typedef struct packed {
        logic              ram_we;
        logic              wr_cipher;
        logic [ADDR_W-1:0] waddr;
        logic [ADDR_W-1:0] raddr_a;
        logic [ADDR_W-1:0] raddr_b;
        logic              cap_xy;
        logic              cap_mix;
        logic              sum_init;
        logic              sum_step;
        logic              out_load;
        logic              mode;
        logic [ADDR_W-1:0] pos;
        logic [ROUND_W-1:0] rounds;
    } xx_cmd_t;

endpackage

>>> rtl/core/xxtea_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA generic RAM
// One write port and two read ports, read data registered.
// ----------------------------------------------------------------------------
module xxtea_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr_a,
    output logic [WIDTH-1:0]         rdata_a,
    input  logic [$clog2(DEPTH)-1:0] raddr_b,
    output logic [WIDTH-1:0]         rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_a_reg;
    logic [WIDTH-1:0] rdata_b_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_a_reg <= mem[raddr_a];
        rdata_b_reg <= mem[raddr_b];
    end

    assign rdata_a = rdata_a_reg;
    assign rdata_b = rdata_b_reg;

endmodule

>>> rtl/core/xxtea_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA datapath
// Word store, key registers, the shared MX round unit and the output word.
// ----------------------------------------------------------------------------
module xxtea_dp
    import xxtea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  xx_cmd_t              cmd,
    input  logic [WORD_W-1:0]    in_word,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output logic [WORD_W-1:0]    out_word
);

    logic [WORD_W-1:0] key_reg [KEY_CNT];
    logic [WORD_W-1:0] x_reg;
    logic [WORD_W-1:0] y_reg;
    logic [WORD_W-1:0] mix_reg;
    logic [WORD_W-1:0] mix_next;
    logic [WORD_W-1:0] sum_reg;
    logic [WORD_W-1:0] sum_next;
    logic [WORD_W-1:0] out_word_reg;
    logic [WORD_W-1:0] rdata_a;
    logic [WORD_W-1:0] rdata_b;
    logic [WORD_W-1:0] wdata;
    logic [WORD_W-1:0] mx_a;
    logic [WORD_W-1:0] mx_b;
    logic [KEY_IDX_W-1:0] key_sel;

    xxtea_ram #(
        .WIDTH (WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_store (
        .clk     (clk),
        .we      (cmd.ram_we),
        .waddr   (cmd.waddr),
        .wdata   (wdata),
        .raddr_a (cmd.raddr_a),
        .rdata_a (rdata_a),
        .raddr_b (cmd.raddr_b),
        .rdata_b (rdata_b)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < KEY_CNT; i++)
            begin
                key_reg[i] <= '0;
            end
        end
        else if (cfg_we)
        begin
            key_reg[cfg_index] <= cfg_data;
        end
    end

    // During the mix cycle the z neighbor sits on read port A.
    always_comb
    begin
        key_sel  = KEY_IDX_W'(cmd.pos) ^ sum_reg[3:2];
        mx_a     = ((rdata_a >> 5) ^ (y_reg << 2)) + ((y_reg >> 3) ^ (rdata_a << 4));
        mx_b     = (sum_reg ^ y_reg) + (key_reg[key_sel] ^ rdata_a);
        mix_next = mx_a ^ mx_b;
    end

    always_comb
    begin
        sum_next = sum_reg;
        if (cmd.sum_init)
        begin
            sum_next = cmd.mode ? WORD_W'(cmd.rounds * DELTA) : DELTA;
        end
        else if (cmd.sum_step)
        begin
            sum_next = cmd.mode ? (sum_reg - DELTA) : (sum_reg + DELTA);
        end
    end

    assign wdata = cmd.wr_cipher ? (cmd.mode ? (x_reg - mix_reg) : (x_reg + mix_reg))
                                 : in_word;

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        if (cmd.cap_xy)
        begin
            x_reg <= rdata_a;
            y_reg <= rdata_b;
        end
        if (cmd.cap_mix)
        begin
            mix_reg <= mix_next;
        end
        if (cmd.out_load)
        begin
            out_word_reg <= rdata_a;
        end
    end

    assign out_word = out_word_reg;

endmodule

>>> rtl/core/xxtea_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA controller
// Sequences loading, the round/word loops of the cipher and the unload.
// ----------------------------------------------------------------------------
module xxtea_ctrl
    import xxtea_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    input  logic    decrypt,
    input  logic    in_last,
    output logic    out_valid,
    input  logic    out_stall,
    output logic    out_last,
    output logic [1:0] status,
    output xx_cmd_t cmd
);

    localparam logic [3:0] S_LOAD     = 4'd0;
    localparam logic [3:0] S_START    = 4'd1;
    localparam logic [3:0] S_RD0      = 4'd2;
    localparam logic [3:0] S_RD1      = 4'd3;
    localparam logic [3:0] S_MIX      = 4'd4;
    localparam logic [3:0] S_WR       = 4'd5;
    localparam logic [3:0] S_OUT_RD   = 4'd6;
    localparam logic [3:0] S_OUT_LD   = 4'd7;
    localparam logic [3:0] S_OUT_HOLD = 4'd8;

    logic [3:0]         state_reg, state_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic               mode_reg, mode_next;
    logic               ovf_reg, ovf_next;
    logic [ADDR_W-1:0]  pos_reg, pos_next;
    logic [ROUND_W-1:0] rounds_reg, rounds_next;
    logic [ADDR_W-1:0]  idx_reg, idx_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    logic [1:0]         status_reg, status_next;

    logic [ADDR_W-1:0]  last_pos;
    logic [ADDR_W-1:0]  pos_plus;
    logic [ADDR_W-1:0]  pos_minus;
    logic               round_end;

    assign last_pos  = ADDR_W'(count_reg - CNT_W'(1));
    assign pos_plus  = (pos_reg == last_pos) ? '0 : pos_reg + ADDR_W'(1);
    assign pos_minus = (pos_reg == '0) ? last_pos : pos_reg - ADDR_W'(1);
    assign round_end = mode_reg ? (pos_reg == '0) : (pos_reg == last_pos);

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        mode_next      = mode_reg;
        ovf_next       = ovf_reg;
        pos_next       = pos_reg;
        rounds_next    = rounds_reg;
        idx_next       = idx_reg;
        out_valid_next = out_valid_reg;
        out_last_next  = out_last_reg;
        status_next    = status_reg;

        cmd            = '0;
        cmd.mode       = mode_reg;
        cmd.pos        = pos_reg;
        cmd.rounds     = rounds_reg;

        unique case (state_reg)
            S_LOAD:
            begin
                if (in_valid)
                begin
                    if (count_reg == '0)
                    begin
                        mode_next = decrypt;
                    end
                    if (count_reg < CNT_W'(MAX_WORDS))
                    begin
                        cmd.ram_we = 1'b1;
                        cmd.waddr  = ADDR_W'(count_reg);
                        count_next = count_reg + CNT_W'(1);
                    end
                    else
                    begin
                        ovf_next = 1'b1;
                    end
                    if (in_last)
                    begin
                        rounds_next = rounds_for(count_next);
                        idx_next    = '0;
                        if (count_next <= CNT_W'(1))
                        begin
                            status_next = ST_SINGLE;
                            state_next  = S_OUT_RD;
                        end
                        else
                        begin
                            status_next = ovf_next ? ST_OVERFLOW : ST_OK;
                            state_next  = S_START;
                        end
                    end
                end
            end
            S_START:
            begin
                cmd.sum_init = 1'b1;
                pos_next     = mode_reg ? last_pos : '0;
                state_next   = S_RD0;
            end
            S_RD0:
            begin
                cmd.raddr_a = pos_reg;
                cmd.raddr_b = pos_plus;
                state_next  = S_RD1;
            end
            S_RD1:
            begin
                cmd.cap_xy  = 1'b1;
                cmd.raddr_a = pos_minus;
                state_next  = S_MIX;
            end
            S_MIX:
            begin
                cmd.cap_mix = 1'b1;
                state_next  = S_WR;
            end
            S_WR:
            begin
                cmd.ram_we    = 1'b1;
                cmd.wr_cipher = 1'b1;
                cmd.waddr     = pos_reg;
                if (round_end)
                begin
                    cmd.sum_step = 1'b1;
                    if (rounds_reg == ROUND_W'(1))
                    begin
                        idx_next   = '0;
                        state_next = S_OUT_RD;
                    end
                    else
                    begin
                        rounds_next = rounds_reg - ROUND_W'(1);
                        pos_next    = mode_reg ? last_pos : '0;
                        state_next  = S_RD0;
                    end
                end
                else
                begin
                    pos_next   = mode_reg ? pos_minus : pos_plus;
                    state_next = S_RD0;
                end
            end
            S_OUT_RD:
            begin
                cmd.raddr_a = idx_reg;
                state_next  = S_OUT_LD;
            end
            S_OUT_LD:
            begin
                cmd.out_load   = 1'b1;
                out_valid_next = 1'b1;
                out_last_next  = (idx_reg == last_pos);
                state_next     = S_OUT_HOLD;
            end
            S_OUT_HOLD:
            begin
                if (!out_stall)
                begin
                    out_valid_next = 1'b0;
                    if (out_last_reg)
                    begin
                        count_next = '0;
                        mode_next  = 1'b0;
                        ovf_next   = 1'b0;
                        state_next = S_LOAD;
                    end
                    else
                    begin
                        idx_next   = idx_reg + ADDR_W'(1);
                        state_next = S_OUT_RD;
                    end
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            count_reg     <= '0;
            mode_reg      <= 1'b0;
            ovf_reg       <= 1'b0;
            pos_reg       <= '0;
            rounds_reg    <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            status_reg    <= ST_OK;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            mode_reg      <= mode_next;
            ovf_reg       <= ovf_next;
            pos_reg       <= pos_next;
            rounds_reg    <= rounds_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
            status_reg    <= status_next;
        end
    end

    assign in_stall  = (state_reg != S_LOAD);
    assign out_valid = out_valid_reg;
    assign out_last  = out_last_reg;
    assign status    = status_reg;

endmodule

>>> rtl/core/xxtea_block_cipher_top.sv
// Words are stored as accepted. For n >= 2 words, the last one is followed by
// a setup step and (6 + 52/n) * n MX word updates, each a read, capture, mix
// and write step, as the MX unit is shared and the store has two read ports;
// then each word is read, loaded and held until taken. One message at a time.
// Reset: asynchronous, active low; clears control state and the key words,
// the word store is not cleared.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA block cipher top level
// Collects a message of 32-bit words, ciphers it in place with XXTEA (a
// single-word message is left as is) and streams the words back out in order.
// ----------------------------------------------------------------------------
module xxtea_block_cipher_top
    import xxtea_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // Input channel: one transaction per message word.
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [WORD_W-1:0]    in_word,
    input  logic                 decrypt,
    input  logic                 in_last,
    // Output channel: one transaction per processed word.
    output logic                 out_valid,
    input  logic                 out_stall,
    output logic [WORD_W-1:0]    out_word,
    output logic                 out_last,
    output logic [1:0]           status,
    // Configuration channel for the four key words.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data
);

    xx_cmd_t cmd;
    logic    cfg_we;

    // Key registers are plain flops, so a configuration transaction is
    // always taken without a stall.
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    // The controller owns the word count, mode, overflow flag, the round
    // and word position loops and the output handshake. It drives the
    // datapath purely through the command struct.
    xxtea_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .decrypt   (decrypt),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_last  (out_last),
        .status    (status),
        .cmd       (cmd)
    );

    // The datapath holds the word store, the keys, the running sum and
    // the MX unit. Each word update reads the target word and both of its
    // ring neighbors from the store, so no separate y/z carry is needed.
    xxtea_dp u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .in_word   (in_word),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out_word  (out_word)
    );

    // No input is taken while a result word is being offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> in_stall)
        else $error("input accepted while output is pending");

    // The word that closes a message stops further input at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && in_last) |=> in_stall)
        else $error("input not stalled after last word");

    // After the final output transaction of a message, nothing more is offered.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && out_last) |=> (!out_valid && !in_stall))
        else $error("block did not return to loading after last output");

    // Status stays constant across all words of one message.
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !out_last) |=> $stable(status))
        else $error("status changed within a message");

endmodule

>>> test/tb_xxtea_block_cipher_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// XXTEA block cipher testbench
// Feeds messages of 32-bit words into the cipher under several keys, then
// compares every output word, last flag and status with a cycle-free
// software model of XXTEA kept alongside the stimulus.
// ----------------------------------------------------------------------------
module tb_xxtea_block_cipher_top
    import xxtea_pkg::*;
();

    // Clock period is 12 ns. The run-time limit is far above the slowest
    // legal run.
    localparam int          RESET_CYCLES = 11;
    localparam int          DRAIN_CYCLES = 16;
    localparam int          HOLD_CYCLES  = 400;
    localparam int unsigned TIMEOUT_NS   = 12_000_000;

    // One expected output transaction.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              last;
        logic [1:0]        st;
    } cipher_result_t;

    // One row of the directed table. Rows with typed set carry their
    // expected output word and status; all other rows go to the model.
    typedef struct packed {
        logic [WORD_W-1:0] word;
        logic              dec;
        logic              last;
        logic              typed;
        logic [WORD_W-1:0] typed_word;
        logic [1:0]        typed_st;
    } dir_row_t;

    localparam int DIR_ROW_CNT = 22;
    localparam dir_row_t DIR_ROWS [0:DIR_ROW_CNT-1] = '{
        // Single-word messages pass through unchanged and are flagged.
        '{32'h0000_0000, 1'b0, 1'b1, 1'b1, 32'h0000_0000, ST_SINGLE},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b1, 32'hFFFF_FFFF, ST_SINGLE},
        '{32'hA5A5_A5A5, 1'b0, 1'b1, 1'b1, 32'hA5A5_A5A5, ST_SINGLE},
        // Shortest ciphered messages at both word extremes, both modes.
        '{32'h0000_0000, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'h0000_0000, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'hFFFF_FFFF, 1'b1, 1'b1, 1'b0, 32'h0, ST_OK},
        // The decrypt bit of later words must be ignored.
        '{32'h0123_4567, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'h89AB_CDEF, 1'b1, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'hFEDC_BA98, 1'b1, 1'b1, 1'b0, 32'h0, ST_OK},
        '{32'h7654_3210, 1'b1, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'h0F0F_0F0F, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'hF0F0_F0F0, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        // Sign-boundary words, encrypt.
        '{32'h8000_0000, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'h7FFF_FFFF, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'h0000_0001, 1'b1, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'hFFFF_FFFE, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK},
        // Five-word decrypt.
        '{32'h1357_9BDF, 1'b1, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'h2468_ACE0, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'h5555_5555, 1'b0, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0, 32'h0, ST_OK},
        '{32'h3C3C_C3C3, 1'b0, 1'b1, 1'b0, 32'h0, ST_OK}
    };

    // DUT ports. Every input has a known value from time zero.
    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic [WORD_W-1:0]    in_word   = '0;
    logic                 decrypt   = 1'b0;
    logic                 in_last   = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [WORD_W-1:0]    out_word;
    logic                 out_last;
    logic [1:0]           status;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [WORD_W-1:0]    cfg_data  = '0;

    // Software copy of the cipher state, updated on every accepted input
    // transaction and on every key write.
    logic [WORD_W-1:0] shadow_key   [KEY_CNT];
    logic [WORD_W-1:0] shadow_words [MAX_WORDS];
    int unsigned       shadow_count   = 0;
    logic              shadow_decrypt = 1'b0;
    logic              shadow_dropped = 1'b0;

    // Output words still owed by the DUT, oldest first.
    cipher_result_t cipher_expected [$];

    // Control between the stimulus thread and the output stall thread.
    bit burst_mode = 1'b0;
    bit hold_req   = 1'b0;

    // Run statistics.
    int mismatch_count  = 0;
    int results_checked = 0;
    int words_sent      = 0;
    int msgs_sent       = 0;
    int single_msgs     = 0;
    int overflow_msgs   = 0;
    int decrypt_msgs    = 0;
    int key_settings    = 1;
    int holds_done      = 0;

    xxtea_block_cipher_top DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .decrypt   (decrypt),
        .in_last   (in_last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .out_last  (out_last),
        .status    (status),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // Hard stop in case the DUT hangs.
    initial
    begin
        #(TIMEOUT_NS);
        $display("Run-time limit reached with %0d output words still owed.",
                 cipher_expected.size());
        $display("TEST FAILED");
        $finish;
    end

    // ------------------------------------------------------------------
    // Cipher model
    // ------------------------------------------------------------------

    // The XXTEA mixing function for one word update.
    function automatic logic [WORD_W-1:0] xxtea_mix(input logic [WORD_W-1:0] y,
                                                    input logic [WORD_W-1:0] z,
                                                    input logic [WORD_W-1:0] sum,
                                                    input int unsigned       p,
                                                    input logic [1:0]        e);
        logic [WORD_W-1:0] a;
        logic [WORD_W-1:0] b;
        logic [1:0]        kidx;
        kidx = p[1:0] ^ e;
        a = ((z >> 5) ^ (y << 2)) + ((y >> 3) ^ (z << 4));
        b = (sum ^ y) + (shadow_key[kidx] ^ z);
        return a ^ b;
    endfunction

    function automatic void xxtea_encrypt_store(input int unsigned n);
        int unsigned       rounds;
        int unsigned       p;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [1:0]        e;
        rounds = 6 + 52 / n;
        sum    = '0;
        z      = shadow_words[n-1];
        repeat (rounds)
        begin
            sum = sum + DELTA;
            e   = sum[3:2];
            for (p = 0; p < n - 1; p++)
            begin
                y = shadow_words[p+1];
                shadow_words[p] = shadow_words[p] + xxtea_mix(y, z, sum, p, e);
                z = shadow_words[p];
            end
            y = shadow_words[0];
            shadow_words[n-1] = shadow_words[n-1] + xxtea_mix(y, z, sum, n - 1, e);
            z = shadow_words[n-1];
        end
    endfunction

    function automatic void xxtea_decrypt_store(input int unsigned n);
        int unsigned       rounds;
        int unsigned       p;
        logic [WORD_W-1:0] sum;
        logic [WORD_W-1:0] y;
        logic [WORD_W-1:0] z;
        logic [1:0]        e;
        rounds = 6 + 52 / n;
        sum    = WORD_W'(rounds) * DELTA;
        y      = shadow_words[0];
        repeat (rounds)
        begin
            e = sum[3:2];
            for (p = n - 1; p > 0; p--)
            begin
                z = shadow_words[p-1];
                shadow_words[p] = shadow_words[p] - xxtea_mix(y, z, sum, p, e);
                y = shadow_words[p];
            end
            z = shadow_words[n-1];
            shadow_words[0] = shadow_words[0] - xxtea_mix(y, z, sum, 0, e);
            y = shadow_words[0];
            sum = sum - DELTA;
        end
    endfunction

    // Absorbs one accepted input word. On the last word of a message it
    // ciphers the stored words and, if asked to, queues them as expected.
    function automatic void xxtea_absorb_word(input logic [WORD_W-1:0] w,
                                              input logic              dec,
                                              input logic              last,
                                              input bit                queue_it);
        cipher_result_t r;
        int unsigned    n;
        int unsigned    i;
        logic [1:0]     st;
        if (shadow_count == 0)
            shadow_decrypt = dec;
        if (shadow_count < MAX_WORDS)
        begin
            shadow_words[shadow_count] = w;
            shadow_count++;
        end
        else
            shadow_dropped = 1'b1;
        if (!last)
            return;
        n = shadow_count;
        if (n <= 1)
            st = ST_SINGLE;
        else
        begin
            st = shadow_dropped ? ST_OVERFLOW : ST_OK;
            if (shadow_decrypt)
                xxtea_decrypt_store(n);
            else
                xxtea_encrypt_store(n);
        end
        if (queue_it)
            for (i = 0; i < n; i++)
            begin
                r.word = shadow_words[i];
                r.last = (i == n - 1);
                r.st   = st;
                cipher_expected.push_back(r);
            end
        shadow_count   = 0;
        shadow_decrypt = 1'b0;
        shadow_dropped = 1'b0;
    endfunction

    // ------------------------------------------------------------------
    // Random helpers
    // ------------------------------------------------------------------

    // Idle length: mostly none or short, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // Message length in words: mostly short, a few up to a full store.
    function automatic int pick_msg_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 10)
            return 1;
        else if (r < 70)
            return $urandom_range(2, 8);
        else if (r < 88)
            return $urandom_range(9, 26);
        else if (r < 97)
            return $urandom_range(27, 52);
        return $urandom_range(53, MAX_WORDS);
    endfunction

    // Message word with extra weight on all-zeros and all-ones.
    function automatic logic [WORD_W-1:0] pick_word();
        int r;
        r = $urandom_range(0, 15);
        if (r == 0)
            return '0;
        else if (r == 1)
            return '1;
        return $urandom;
    endfunction

    // ------------------------------------------------------------------
    // Reporting and output checking
    // ------------------------------------------------------------------

    task automatic report_mismatch(input string             what,
                                   input logic [WORD_W-1:0] got,
                                   input logic [WORD_W-1:0] want);
        mismatch_count++;
        $display("%0t ns: %s mismatch: got %h, expected %h", $time, what, got, want);
    endtask

    // Each output transaction is compared with the oldest expected word.
    // Values are sampled at the rising edge, before any update at that edge
    // takes effect.
    always @(posedge clk)
    begin
        cipher_result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (cipher_expected.size() == 0)
                report_mismatch("unexpected output word", out_word, '0);
            else
            begin
                want = cipher_expected.pop_front();
                results_checked++;
                if (out_word !== want.word)
                    report_mismatch("out_word", out_word, want.word);
                if (out_last !== want.last)
                    report_mismatch("out_last", 32'(out_last), 32'(want.last));
                if (status !== want.st)
                    report_mismatch("status", 32'(status), 32'(want.st));
            end
        end
    end

    // ------------------------------------------------------------------
    // Output stall generator
    // ------------------------------------------------------------------

    // Normally the receiver stalls for random stretches. In burst mode it
    // never stalls. On a hold request it stalls without a break for a run
    // counted here from HOLD_CYCLES, while the stimulus thread keeps offering
    // words so the DUT fills up and stalls its input.
    initial
    begin
        int gap;
        int hold_left;
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                out_stall <= 1'b1;
                for (hold_left = HOLD_CYCLES; hold_left > 0; hold_left--)
                    @(posedge clk);
                out_stall <= 1'b0;
                hold_req = 1'b0;
                holds_done++;
            end
            else if (burst_mode)
                out_stall <= 1'b0;
            else
            begin
                gap = pick_gap();
                if (gap > 0)
                begin
                    out_stall <= 1'b1;
                    repeat (gap)
                        @(posedge clk);
                end
                out_stall <= 1'b0;
                repeat ($urandom_range(0, 6))
                    @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus tasks. All of them are entered and left at a rising edge.
    // ------------------------------------------------------------------

    // Offers one word and waits until the DUT takes it. The valid stays
    // high on return so that back-to-back words need no second drive of
    // in_valid in the same time step.
    task automatic push_word(input logic [WORD_W-1:0] w,
                             input logic              dec,
                             input logic              last,
                             input bit                typed,
                             input logic [WORD_W-1:0] typed_word,
                             input logic [1:0]        typed_st);
        int             gap;
        cipher_result_t r;
        gap = burst_mode ? 0 : pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        decrypt  <= dec;
        in_last  <= last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        // The transaction happened at this edge.
        words_sent++;
        if (typed)
        begin
            r.word = typed_word;
            r.last = 1'b1;
            r.st   = typed_st;
            cipher_expected.push_back(r);
        end
        xxtea_absorb_word(w, dec, last, !typed);
    endtask

    // Sends one whole message. Later words carry a random decrypt bit,
    // which the DUT has to ignore.
    task automatic send_message(input int len, input logic dec);
        int i;
        msgs_sent++;
        if (len == 1)
            single_msgs++;
        else if (dec)
            decrypt_msgs++;
        if (len > MAX_WORDS)
            overflow_msgs++;
        for (i = 0; i < len; i++)
            push_word(pick_word(), (i == 0) ? dec : 1'($urandom_range(0, 1)),
                      i == len - 1, 1'b0, '0, ST_OK);
    endtask

    // Waits until every owed word has come out, then lets the DUT settle.
    task automatic wait_idle();
        while (cipher_expected.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
    endtask

    // Writes all four key words while the DUT is idle. Valid is held high
    // across the four transactions.
    task automatic load_key(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                            input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3);
        logic [WORD_W-1:0] key [KEY_CNT];
        int                i;
        key = '{k0, k1, k2, k3};
        for (i = 0; i < KEY_CNT; i++)
        begin
            cfg_valid <= 1'b1;
            cfg_index <= CFG_IDX_W'(i);
            cfg_data  <= key[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            shadow_key[i] = key[i];
        end
        cfg_valid <= 1'b0;
        key_settings++;
    endtask

    // One phase: new key, then random messages until the word budget is
    // spent. The input valid is left high; the caller drops it.
    task automatic run_phase(input logic [WORD_W-1:0] k0, input logic [WORD_W-1:0] k1,
                             input logic [WORD_W-1:0] k2, input logic [WORD_W-1:0] k3,
                             input int budget, input bit hold_off);
        int start;
        wait_idle();
        load_key(k0, k1, k2, k3);
        if (hold_off)
            hold_req = 1'b1;
        start = words_sent;
        while (words_sent - start < budget)
            send_message(pick_msg_len(), 1'($urandom_range(0, 1)));
    endtask

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        int i;
        for (i = 0; i < KEY_CNT; i++)
            shadow_key[i] = '0;

        // Single reset at the start of the run.
        repeat (RESET_CYCLES)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table under the all-zero key left by reset.
        for (i = 0; i < DIR_ROW_CNT; i++)
        begin
            if (i == 0 || DIR_ROWS[i-1].last)
            begin
                msgs_sent++;
                if (DIR_ROWS[i].last)
                    single_msgs++;
                else if (DIR_ROWS[i].dec)
                    decrypt_msgs++;
            end
            push_word(DIR_ROWS[i].word, DIR_ROWS[i].dec, DIR_ROWS[i].last,
                      DIR_ROWS[i].typed, DIR_ROWS[i].typed_word, DIR_ROWS[i].typed_st);
        end
        in_valid <= 1'b0;

        // Random phases across key settings, the extremes among them.
        run_phase('1, '1, '1, '1, 25, 1'b0);
        in_valid <= 1'b0;

        // A stretch with no idling on either side.
        burst_mode = 1'b1;
        run_phase($urandom, $urandom, $urandom, $urandom, 25, 1'b0);
        in_valid <= 1'b0;
        wait_idle();
        burst_mode = 1'b0;

        // Long receiver hold-off while words keep coming in.
        run_phase('0, '0, '0, '0, 25, 1'b1);
        in_valid <= 1'b0;

        // A message that fills the store exactly, then two that overflow
        // it, one per mode; the dropped last word still ends each message.
        run_phase($urandom, $urandom, $urandom, $urandom, 25, 1'b0);
        send_message(MAX_WORDS, 1'($urandom_range(0, 1)));
        send_message(MAX_WORDS + $urandom_range(1, 6), 1'b0);
        send_message(MAX_WORDS + $urandom_range(1, 6), 1'b1);
        in_valid <= 1'b0;

        run_phase('0, '1, $urandom, $urandom, 25, 1'b0);
        in_valid <= 1'b0;

        wait_idle();

        $display("Sent %0d words in %0d messages (%0d single-word, %0d overflowing, %0d decrypt)",
                 words_sent, msgs_sent, single_msgs, overflow_msgs, decrypt_msgs);
        $display("under %0d keys with %0d long hold-offs; %0d output words checked, %0d errors",
                 key_settings, holds_done, results_checked, mismatch_count);
        if (mismatch_count == 0 && cipher_expected.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/xxtea_pkg.sv
rtl/core/xxtea_ram.sv
rtl/core/xxtea_dp.sv
rtl/core/xxtea_ctrl.sv
rtl/core/xxtea_block_cipher_top.sv
test/tb_xxtea_block_cipher_top.sv
